@@ hw/rtl/qoi_enc_pkg.sv @@
// Shared types, chunk opcodes and the index hash of the QOI chunk encoder.
// No dependencies; the chunk former, output buffer and top level import this package.
package qoi_enc_pkg;

   localparam int TABLE_DEPTH = 64;
   localparam int HASH_W      = 6;
   localparam int MAX_BYTES   = 6;
   localparam int CNT_W       = 3;
   localparam int RUN_W       = 6;
   localparam int RUN_MAX     = 62;

   localparam logic [7:0] OP_INDEX     = 8'h00;
   localparam logic [7:0] OP_DIFF      = 8'h40;
   localparam logic [7:0] OP_LUMA      = 8'h80;
   localparam logic [7:0] OP_RUN       = 8'hc0;
   localparam logic [7:0] OP_RGB       = 8'hfe;
   localparam logic [7:0] OP_RGBA      = 8'hff;
   localparam logic [7:0] ALPHA_OPAQUE = 8'hff;
   localparam logic [7:0] DIFF_BIAS    = 8'd2;
   localparam logic [7:0] LUMA_BIAS_G  = 8'd30;
   localparam logic [7:0] LUMA_BIAS_RB = 8'd38;

   typedef struct packed {
      logic [7:0] r;
      logic [7:0] g;
      logic [7:0] b;
      logic [7:0] a;
   } pixel_type;

   localparam pixel_type RESET_PIXEL = '{r: 8'h00, g: 8'h00, b: 8'h00, a: 8'hff};

   // bytes[0] leaves first
   typedef struct packed {
      logic [MAX_BYTES-1:0][7:0] bytes;
      logic [CNT_W-1:0]          count;
      logic                      last;
   } chunk_type;

   function automatic logic [HASH_W-1:0] pixel_hash(pixel_type p);
      logic [HASH_W-1:0] r6;
      logic [HASH_W-1:0] g6;
      logic [HASH_W-1:0] b6;
      logic [HASH_W-1:0] a6;
      r6 = p.r[HASH_W-1:0];
      g6 = p.g[HASH_W-1:0];
      b6 = p.b[HASH_W-1:0];
      a6 = p.a[HASH_W-1:0];
      // only the low six bits matter, so wrap in six bits
      return r6 * 6'd3 + g6 * 6'd5 + b6 * 6'd7 + a6 * 6'd11;
   endfunction

endpackage

@@ hw/rtl/qoi_enc_if.sv @@
// Handshake channels of the QOI chunk encoder: pixel in, byte out, register write.
// Standalone; no package dependency.
interface qoi_pix_if;
   logic       valid;
   logic       ready;
   logic [7:0] red;
   logic [7:0] green;
   logic [7:0] blue;
   logic [7:0] alpha;
   logic       last_pixel;

   modport source (output valid, red, green, blue, alpha, last_pixel, input ready);
   modport sink   (input valid, red, green, blue, alpha, last_pixel, output ready);
endinterface

interface qoi_byte_if;
   logic       valid;
   logic       ready;
   logic [7:0] out_byte;
   logic       pixel_done;
   logic       image_done;

   modport source (output valid, out_byte, pixel_done, image_done, input ready);
   modport sink   (input valid, out_byte, pixel_done, image_done, output ready);
endinterface

interface qoi_csr_if;
   logic valid;
   logic ready;
   logic has_alpha;

   modport source (output valid, has_alpha, input ready);
   modport sink   (input valid, has_alpha, output ready);
endinterface

@@ hw/rtl/qoi_enc_ram.sv @@
// Generic single-write, single-read RAM with registered read data (read-first).
// No dependencies.
module qoi_enc_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

@@ hw/rtl/qoi_enc_chunk.sv @@
// Chunk former: turns one pixel plus encoder state into up to six chunk bytes.
// Uses qoi_enc_pkg; purely combinational, sits between input and output registers.
module qoi_enc_chunk
   import qoi_enc_pkg::*;
(
   input  pixel_type         pix,
   input  logic              last,
   input  pixel_type         prev,
   input  logic [RUN_W-1:0]  run,
   input  logic [HASH_W-1:0] hash,
   input  pixel_type         entry,
   output chunk_type         chunk,
   output logic [RUN_W-1:0]  run_next,
   output logic              tab_wr
);

   logic [7:0]       dr;
   logic [7:0]       dg;
   logic [7:0]       db;
   logic [7:0]       lg;
   logic [7:0]       rg;
   logic [7:0]       bg;
   logic [RUN_W-1:0] run_inc;
   logic [CNT_W-1:0] n;

   always_comb begin
      dr      = pix.r - prev.r + DIFF_BIAS;
      dg      = pix.g - prev.g + DIFF_BIAS;
      db      = pix.b - prev.b + DIFF_BIAS;
      lg      = dg + LUMA_BIAS_G;
      rg      = dr - lg + LUMA_BIAS_RB;
      bg      = db - lg + LUMA_BIAS_RB;
      run_inc = run + RUN_W'(1);

      chunk    = '0;
      n        = '0;
      run_next = run;
      tab_wr   = 1'b0;

      if (pix == prev) begin
         run_next = run_inc;
         if (run_inc == RUN_W'(RUN_MAX)) begin
            chunk.bytes[n] = OP_RUN | 8'(RUN_MAX - 1);
            n              = n + CNT_W'(1);
            run_next       = '0;
         end
         // final pixel flushes what remains of the run
         if (last && run_next != '0) begin
            chunk.bytes[n] = OP_RUN | {2'b00, run_next - RUN_W'(1)};
            n              = n + CNT_W'(1);
            run_next       = '0;
         end
      end else begin
         run_next = '0;
         if (run != '0) begin
            chunk.bytes[n] = OP_RUN | {2'b00, run - RUN_W'(1)};
            n              = n + CNT_W'(1);
         end
         if (entry == pix) begin
            chunk.bytes[n] = OP_INDEX | {2'b00, hash};
            n              = n + CNT_W'(1);
         end else begin
            tab_wr = 1'b1;
            if (pix.a == prev.a) begin
               if (dr[7:2] == '0 && dg[7:2] == '0 && db[7:2] == '0) begin
                  chunk.bytes[n] = OP_DIFF | {2'b00, dr[1:0], dg[1:0], db[1:0]};
                  n              = n + CNT_W'(1);
               end else if (lg[7:6] == '0 && rg[7:4] == '0 && bg[7:4] == '0) begin
                  chunk.bytes[n] = OP_LUMA | lg;
                  n              = n + CNT_W'(1);
                  chunk.bytes[n] = {rg[3:0], bg[3:0]};
                  n              = n + CNT_W'(1);
               end else begin
                  chunk.bytes[n] = OP_RGB;
                  n              = n + CNT_W'(1);
                  chunk.bytes[n] = pix.r;
                  n              = n + CNT_W'(1);
                  chunk.bytes[n] = pix.g;
                  n              = n + CNT_W'(1);
                  chunk.bytes[n] = pix.b;
                  n              = n + CNT_W'(1);
               end
            end else begin
               chunk.bytes[n] = OP_RGBA;
               n              = n + CNT_W'(1);
               chunk.bytes[n] = pix.r;
               n              = n + CNT_W'(1);
               chunk.bytes[n] = pix.g;
               n              = n + CNT_W'(1);
               chunk.bytes[n] = pix.b;
               n              = n + CNT_W'(1);
               chunk.bytes[n] = pix.a;
               n              = n + CNT_W'(1);
            end
         end
      end

      chunk.count = n;
      chunk.last  = last;
   end

endmodule

@@ hw/rtl/qoi_enc_out.sv @@
// Output buffer: holds one pixel's chunk bytes and sends them one per transaction.
// Uses qoi_enc_pkg and the qoi_byte_if channel.
module qoi_enc_out
   import qoi_enc_pkg::*;
(
   input  logic      clock,
   input  logic      reset,
   input  logic      load,
   input  chunk_type chunk_in,
   output logic      free,
   qoi_byte_if.source rsp
);

   logic [MAX_BYTES-1:0][7:0] bytes_ff;
   logic [CNT_W-1:0]          cnt_ff;
   logic [CNT_W-1:0]          idx_ff;
   logic                      last_ff;
   logic                      final_byte;

   assign final_byte     = (idx_ff == cnt_ff - CNT_W'(1));
   assign rsp.valid      = (cnt_ff != '0);
   assign rsp.out_byte   = bytes_ff[idx_ff];
   assign rsp.pixel_done = final_byte;
   assign rsp.image_done = final_byte & last_ff;
   // buffer can take new bytes when empty or when its final byte leaves now
   assign free = (cnt_ff == '0) || (rsp.ready && final_byte);

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
         idx_ff <= '0;
      end else if (load) begin
         cnt_ff <= chunk_in.count;
         idx_ff <= '0;
      end else if (rsp.valid && rsp.ready) begin
         if (final_byte) begin
            cnt_ff <= '0;
            idx_ff <= '0;
         end else begin
            idx_ff <= idx_ff + CNT_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         bytes_ff <= chunk_in.bytes;
         last_ff  <= chunk_in.last;
      end
   end

endmodule

@@ hw/rtl/qoi_image_encoder.sv @@
// QOI chunk encoder: one RGB(A) pixel per req_pix transaction, one chunk byte per
// rsp_byte transaction. A pixel is registered at acceptance, coded in the next cycle
// and its bytes leave from an output buffer when free; pixels can be taken every
// cycle while it keeps up. A pixel of more than one byte holds back the next input,
// as the output port moves one byte per cycle while rsp_byte is ready; run-extending
// pixels give no byte. The 64-entry index table is a RAM read at the accept edge
// with per-entry valid bits, so reset and the last pixel of an image clear it at
// once. csr_wr sets has_alpha (reset 1); write it only while the encoder is idle.
module qoi_image_encoder
   import qoi_enc_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   qoi_pix_if.sink     req_pix,
   qoi_byte_if.source  rsp_byte,
   qoi_csr_if.sink     csr_wr
);

   logic                   has_alpha_ff;
   logic                   s1_valid_ff;
   pixel_type              pix_ff;
   logic                   last_ff;
   logic [HASH_W-1:0]      hash_ff;
   pixel_type              prev_ff;
   logic [RUN_W-1:0]       run_ff;
   logic [TABLE_DEPTH-1:0] seen_ff;
   logic                   fwd_ff;
   pixel_type              fwd_data_ff;

   pixel_type         pix_in;
   logic [HASH_W-1:0] hash_in;
   logic              accept;
   logic              consume;
   logic              out_free;
   logic              wr_en;
   pixel_type         rd_data;
   pixel_type         entry;
   chunk_type         chunk;
   logic [RUN_W-1:0]  run_next;
   logic              tab_wr;

   assign csr_wr.ready = 1'b1;

   assign pix_in.r = req_pix.red;
   assign pix_in.g = req_pix.green;
   assign pix_in.b = req_pix.blue;
   assign pix_in.a = has_alpha_ff ? req_pix.alpha : ALPHA_OPAQUE;
   assign hash_in  = pixel_hash(pix_in);

   assign consume       = s1_valid_ff && (chunk.count == '0 || out_free);
   assign req_pix.ready = !s1_valid_ff || consume;
   assign accept        = req_pix.valid && req_pix.ready;
   assign wr_en         = consume && tab_wr;

   // a write at the read edge is not in the RAM output: take it from the bypass
   assign entry = !seen_ff[hash_ff] ? pixel_type'('0) : (fwd_ff ? fwd_data_ff : rd_data);

   qoi_enc_ram #(
      .WIDTH ($bits(pixel_type)),
      .DEPTH (TABLE_DEPTH)
   ) u_table (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (hash_ff),
      .wr_data (pix_ff),
      .rd_en   (accept),
      .rd_addr (hash_in),
      .rd_data (rd_data)
   );

   qoi_enc_chunk u_chunk (
      .pix      (pix_ff),
      .last     (last_ff),
      .prev     (prev_ff),
      .run      (run_ff),
      .hash     (hash_ff),
      .entry    (entry),
      .chunk    (chunk),
      .run_next (run_next),
      .tab_wr   (tab_wr)
   );

   qoi_enc_out u_out (
      .clock    (clock),
      .reset    (reset),
      .load     (consume && chunk.count != '0),
      .chunk_in (chunk),
      .free     (out_free),
      .rsp      (rsp_byte)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         has_alpha_ff <= 1'b1;
         s1_valid_ff  <= 1'b0;
         prev_ff      <= RESET_PIXEL;
         run_ff       <= '0;
         seen_ff      <= '0;
         fwd_ff       <= 1'b0;
      end else begin
         if (csr_wr.valid) begin
            has_alpha_ff <= csr_wr.has_alpha;
         end
         if (accept) begin
            s1_valid_ff <= 1'b1;
            fwd_ff      <= wr_en && (hash_ff == hash_in);
         end else if (consume) begin
            s1_valid_ff <= 1'b0;
         end
         if (consume) begin
            if (last_ff) begin
               // start a fresh image
               prev_ff <= RESET_PIXEL;
               run_ff  <= '0;
               seen_ff <= '0;
            end else begin
               prev_ff <= pix_ff;
               run_ff  <= run_next;
               if (tab_wr) begin
                  seen_ff[hash_ff] <= 1'b1;
               end
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         pix_ff      <= pix_in;
         last_ff     <= req_pix.last_pixel;
         hash_ff     <= hash_in;
         fwd_data_ff <= pix_ff;
      end
   end

endmodule
